FILE: rtl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and codes of the byte stack machine execute core: opcodes,
// status codes, channel payloads and the bundles between the pipeline and
// the execute logic.
// ----------------------------------------------------------------------------
package bsm_pkg;

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_PUSH  = 4'd2,
    CMD_JUMP  = 4'd3,
    CMD_DUP   = 4'd4,
    CMD_POP   = 4'd5,
    CMD_JNZ   = 4'd6,
    CMD_JZ    = 4'd7,
    CMD_GT    = 4'd8,
    CMD_LT    = 4'd9,
    CMD_HALT  = 4'd10,
    CMD_WRITE = 4'd11
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OVERFLOW    = 3'd1,
    ST_UNDERFLOW   = 3'd2,
    ST_BAD_JUMP    = 3'd3,
    ST_BAD_OPERAND = 3'd4
  } status_t;

  localparam logic [8:0] PLEN_RESET = 9'd256;

  typedef struct packed {
    logic [3:0] command;
    logic [7:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] next_ip;
    logic       halted_flag;
    logic       write_valid;
    logic [7:0] write_byte;
    logic [7:0] stack_depth;
  } out_item_t;

  typedef struct packed {
    logic [8:0] program_length;
  } cfg_item_t;

  // Architectural state seen by the execute logic (stack pointer apart,
  // its width follows the stack depth).
  typedef struct packed {
    logic [8:0] ip;
    logic       halt;
    logic [7:0] top;
    logic [8:0] plen;
  } arch_t;

  typedef struct packed {
    out_item_t  item;
    logic       we;
    logic [7:0] wdata;
    logic [7:0] top_nxt;
    logic [8:0] ip_nxt;
    logic       halt_nxt;
  } exec_t;

endpackage

FILE: rtl/bsm_chan_if.sv
// ----------------------------------------------------------------------------
// bsm_chan_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface bsm_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/bsm_ram.sv
// ----------------------------------------------------------------------------
// bsm_ram
// Generic RAM: one write port, one read port, registered read data that
// holds while no read is enabled.
// ----------------------------------------------------------------------------
module bsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 255,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bsm_exec.sv
// ----------------------------------------------------------------------------
// bsm_exec
// Execute logic: checks one instruction against the current state, forms
// the result item, the next state and the stack memory write.
// ----------------------------------------------------------------------------
module bsm_exec #(
  parameter int STACK_DEPTH = 255,
  localparam int SPW = $clog2(STACK_DEPTH + 1),
  localparam int AW  = $clog2(STACK_DEPTH),
  localparam int CW  = (SPW > 8) ? SPW : 8
) (
  input  logic [3:0]         cmd,
  input  logic [7:0]         opd,
  input  bsm_pkg::arch_t     st,
  input  logic [SPW-1:0]     sp,
  input  logic [7:0]         rd_data,
  output bsm_pkg::exec_t     res,
  output logic [SPW-1:0]     sp_nxt,
  output logic [AW-1:0]      waddr
);

  logic               adv;
  logic               jmp;
  logic               jmp_bad;
  logic               full;
  logic [2:0]         status;
  logic               wvalid;
  logic [7:0]         wbyte;
  logic [7:0]         bin_r;
  logic [7:0]         dup_v;
  logic [CW-1:0]      opd_x;
  logic [CW-1:0]      sp_x;
  logic [SPW+7:0]     depth_x;

  assign opd_x   = CW'(opd);
  assign sp_x    = CW'(sp);
  assign jmp_bad = {1'b0, opd} >= st.plen;
  assign full    = sp >= SPW'(STACK_DEPTH);
  assign dup_v   = (opd == 8'd0) ? st.top : rd_data;

  // a is the entry below the top (from memory), b the cached top
  always_comb begin
    case (cmd)
      bsm_pkg::CMD_ADD: bin_r = rd_data + st.top;
      bsm_pkg::CMD_SUB: bin_r = rd_data - st.top;
      bsm_pkg::CMD_GT:  bin_r = {7'd0, rd_data > st.top};
      default:          bin_r = {7'd0, rd_data < st.top};
    endcase
  end

  always_comb begin
    status      = bsm_pkg::ST_OK;
    adv         = 1'b0;
    jmp         = 1'b0;
    wvalid      = 1'b0;
    wbyte       = 8'd0;
    sp_nxt      = sp;
    res.top_nxt = st.top;
    res.halt_nxt = st.halt;
    res.we      = 1'b0;
    res.wdata   = 8'd0;
    waddr       = AW'(sp);
    if (!st.halt) begin
      unique case (cmd) inside
        bsm_pkg::CMD_ADD, bsm_pkg::CMD_SUB, bsm_pkg::CMD_GT, bsm_pkg::CMD_LT: begin
          if (sp < SPW'(2)) begin
            status = bsm_pkg::ST_UNDERFLOW;
          end else begin
            res.we      = 1'b1;
            waddr       = AW'(sp - SPW'(2));
            res.wdata   = bin_r;
            res.top_nxt = bin_r;
            sp_nxt      = sp - SPW'(1);
            adv         = 1'b1;
          end
        end
        bsm_pkg::CMD_PUSH: begin
          if (full) begin
            status = bsm_pkg::ST_OVERFLOW;
          end else begin
            res.we      = 1'b1;
            res.wdata   = opd;
            res.top_nxt = opd;
            sp_nxt      = sp + SPW'(1);
            adv         = 1'b1;
          end
        end
        bsm_pkg::CMD_JUMP: begin
          if (jmp_bad) begin
            status = bsm_pkg::ST_BAD_JUMP;
          end else begin
            jmp = 1'b1;
          end
        end
        bsm_pkg::CMD_DUP: begin
          if (opd_x >= sp_x) begin
            status = bsm_pkg::ST_BAD_OPERAND;
          end else if (full) begin
            status = bsm_pkg::ST_OVERFLOW;
          end else begin
            res.we      = 1'b1;
            res.wdata   = dup_v;
            res.top_nxt = dup_v;
            sp_nxt      = sp + SPW'(1);
            adv         = 1'b1;
          end
        end
        bsm_pkg::CMD_POP: begin
          if (sp == '0) begin
            status = bsm_pkg::ST_UNDERFLOW;
          end else begin
            // new top comes from the entry below
            res.top_nxt = rd_data;
            sp_nxt      = sp - SPW'(1);
            adv         = 1'b1;
          end
        end
        bsm_pkg::CMD_JNZ, bsm_pkg::CMD_JZ: begin
          if (jmp_bad) begin
            status = bsm_pkg::ST_BAD_JUMP;
          end else if (sp == '0) begin
            status = bsm_pkg::ST_UNDERFLOW;
          end else if ((st.top != 8'd0) == (cmd == bsm_pkg::CMD_JNZ)) begin
            jmp = 1'b1;
          end else begin
            adv = 1'b1;
          end
        end
        bsm_pkg::CMD_HALT: begin
          res.halt_nxt = 1'b1;
          adv          = 1'b1;
        end
        bsm_pkg::CMD_WRITE: begin
          if (sp == '0) begin
            status = bsm_pkg::ST_UNDERFLOW;
          end else begin
            wvalid = 1'b1;
            wbyte  = st.top;
            adv    = 1'b1;
          end
        end
        default: begin
          status = bsm_pkg::ST_BAD_OPERAND;
        end
      endcase
    end

    res.ip_nxt = adv ? (st.ip + 9'd1) : (jmp ? {1'b0, opd} : st.ip);
    depth_x    = {8'd0, sp_nxt};

    res.item.status      = status;
    res.item.next_ip     = res.ip_nxt;
    res.item.halted_flag = res.halt_nxt;
    res.item.write_valid = wvalid;
    res.item.write_byte  = wbyte;
    res.item.stack_depth = depth_x[7:0];
  end

endmodule

FILE: rtl/byte_stack_machine_execute_core.sv
// ----------------------------------------------------------------------------
// byte_stack_machine_execute_core
// Execute unit of an 8-bit stack machine. The byte stack sits in a RAM with
// a cached top of stack; every instruction reads at most one RAM entry and
// writes at most one.
//
// Channels: in_chan takes one instruction (command, operand) per request,
// out_chan returns one result per instruction, cfg_chan writes
// program_length (always ready).
// Pipeline: the accept cycle issues the RAM read (the entry below the top,
// or the dup source), the execute stage computes, writes the RAM and loads
// the output register. A result comes from the output register, behind the
// execute stage; one instruction per cycle is sustained while out_chan drains.
// A RAM write and a read of the same entry in one cycle are forwarded.
// Reset: stack empty, instruction pointer 0, not halted, program_length
// 256. Stack memory contents are not cleared and need no clearing pass.
// Stall: with the output register full and not taken, the execute stage
// holds its request and in_chan.ready drops until out_chan accepts.
// ----------------------------------------------------------------------------
module byte_stack_machine_execute_core #(
  parameter int STACK_DEPTH = 255
) (
  input  logic          clk,
  input  logic          rst_n,
  bsm_chan_if.sink      in_chan,
  bsm_chan_if.source    out_chan,
  bsm_chan_if.sink      cfg_chan
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int CW  = (SPW > 8) ? SPW : 8;

  // architectural state
  logic [SPW-1:0] sp_r;
  logic [8:0]     ip_r;
  logic           halt_r;
  logic [7:0]     top_r;
  logic [8:0]     plen_r;

  // execute stage
  logic           ex_vld_r;
  logic [3:0]     ex_cmd_r;
  logic [7:0]     ex_opd_r;
  logic           byp_vld_r;
  logic [7:0]     byp_data_r;

  // output register
  logic                out_vld_r;
  bsm_pkg::out_item_t  out_data_r;

  logic                in_fire;
  logic                ex_fire;
  bsm_pkg::arch_t      st;
  bsm_pkg::exec_t      res;
  logic [SPW-1:0]      sp_nxt;
  logic [AW-1:0]       waddr;
  logic [7:0]          ram_q;
  logic [7:0]          rd_data;
  logic [SPW-1:0]      eff_sp;
  logic [CW-1:0]       eff_x;
  logic [CW-1:0]       in_opd_x;
  logic [CW-1:0]       rd_cand;
  logic                rd_ok;
  logic [AW-1:0]       rd_addr;
  logic                byp_hit;

  assign ex_fire       = ex_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !ex_vld_r || ex_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // read address of the next request, against the stack pointer it will see
  assign eff_sp   = ex_fire ? sp_nxt : sp_r;
  assign eff_x    = CW'(eff_sp);
  assign in_opd_x = CW'(in_chan.data.operand);

  always_comb begin
    rd_ok   = 1'b0;
    rd_cand = '0;
    case (in_chan.data.command) inside
      bsm_pkg::CMD_ADD, bsm_pkg::CMD_SUB, bsm_pkg::CMD_GT, bsm_pkg::CMD_LT,
      bsm_pkg::CMD_POP: begin
        rd_ok   = eff_x >= CW'(2);
        rd_cand = eff_x - CW'(2);
      end
      bsm_pkg::CMD_DUP: begin
        rd_ok   = in_opd_x < eff_x;
        rd_cand = eff_x - in_opd_x - CW'(1);
      end
      default: begin
        rd_ok = 1'b0;
      end
    endcase
  end

  assign rd_addr = rd_ok ? AW'(rd_cand) : '0;
  assign byp_hit = ex_fire && res.we && (waddr == rd_addr);
  assign rd_data = byp_vld_r ? byp_data_r : ram_q;

  bsm_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ex_fire && res.we),
    .waddr (waddr),
    .wdata (res.wdata),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign st.ip   = ip_r;
  assign st.halt = halt_r;
  assign st.top  = top_r;
  assign st.plen = plen_r;

  bsm_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .cmd     (ex_cmd_r),
    .opd     (ex_opd_r),
    .st      (st),
    .sp      (sp_r),
    .rd_data (rd_data),
    .res     (res),
    .sp_nxt  (sp_nxt),
    .waddr   (waddr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r     <= '0;
      ip_r     <= '0;
      halt_r   <= 1'b0;
      plen_r   <= bsm_pkg::PLEN_RESET;
      ex_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        plen_r <= cfg_chan.data.program_length;
      end
      if (ex_fire) begin
        sp_r   <= sp_nxt;
        ip_r   <= res.ip_nxt;
        halt_r <= res.halt_nxt;
      end
      if (in_fire) begin
        ex_vld_r <= 1'b1;
      end else if (ex_fire) begin
        ex_vld_r <= 1'b0;
      end
      if (ex_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      top_r      <= res.top_nxt;
      out_data_r <= res.item;
    end
    // hold request and read data while the execute stage stalls
    if (in_fire) begin
      ex_cmd_r   <= in_chan.data.command;
      ex_opd_r   <= in_chan.data.operand;
      byp_vld_r  <= byp_hit;
      byp_data_r <= res.wdata;
    end
  end

  assign out_chan.valid = out_vld_r;
  assign out_chan.data  = out_data_r;

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halted flag cleared");

  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.write_valid) |-> (out_data_r.status == bsm_pkg::ST_OK))
    else $error("byte written with error status");

  a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_fire && res.we) |-> (CW'(waddr) < CW'(sp_nxt)))
    else $error("stack write above new stack pointer");

  a_no_ex_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_fire && halt_r) |-> (!res.we && sp_nxt == sp_r))
    else $error("state changed after halt");

endmodule

FILE: tb/sv/bsm_result_checker.sv
// ----------------------------------------------------------------------------
// bsm_result_checker
// Watches the instruction, result and program length channels of the stack
// machine execute core. Keeps its own copy of the byte stack, the pointers,
// the halted flag and program_length, predicts the result of every accepted
// instruction and compares each accepted result field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module bsm_result_checker
  import bsm_pkg::*;
#(
  parameter int STACK_DEPTH = 255
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  cfg_item_t cfg_data,
  output int        pending,
  output int        errors
);

  logic [7:0] stack_mem [STACK_DEPTH];
  int         sp;
  logic [8:0] ip;
  logic       halted;
  logic [8:0] plen;
  out_item_t  expected_results [$];
  out_item_t  want;

  function automatic out_item_t execute_instr(input in_item_t instr);
    out_item_t  res;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] r;
    logic       adv;
    res = '0;
    res.status = ST_OK;
    adv = 1'b0;
    if (!halted) begin
      case (instr.command)
        CMD_ADD, CMD_SUB, CMD_GT, CMD_LT: begin
          if (sp < 2) begin
            res.status = ST_UNDERFLOW;
          end else begin
            a = stack_mem[sp - 2];
            b = stack_mem[sp - 1];
            case (instr.command)
              CMD_ADD: r = a + b;
              CMD_SUB: r = a - b;
              CMD_GT:  r = {7'd0, a > b};
              default: r = {7'd0, a < b};
            endcase
            stack_mem[sp - 2] = r;
            sp = sp - 1;
            adv = 1'b1;
          end
        end
        CMD_PUSH: begin
          if (sp >= STACK_DEPTH) begin
            res.status = ST_OVERFLOW;
          end else begin
            stack_mem[sp] = instr.operand;
            sp = sp + 1;
            adv = 1'b1;
          end
        end
        CMD_JUMP: begin
          if ({1'b0, instr.operand} >= plen) res.status = ST_BAD_JUMP;
          else ip = {1'b0, instr.operand};
        end
        CMD_DUP: begin
          // depth check wins over the full stack check
          if (int'(instr.operand) >= sp) begin
            res.status = ST_BAD_OPERAND;
          end else if (sp >= STACK_DEPTH) begin
            res.status = ST_OVERFLOW;
          end else begin
            stack_mem[sp] = stack_mem[sp - int'(instr.operand) - 1];
            sp = sp + 1;
            adv = 1'b1;
          end
        end
        CMD_POP: begin
          if (sp < 1) begin
            res.status = ST_UNDERFLOW;
          end else begin
            sp = sp - 1;
            adv = 1'b1;
          end
        end
        CMD_JNZ, CMD_JZ: begin
          if ({1'b0, instr.operand} >= plen) begin
            res.status = ST_BAD_JUMP;
          end else if (sp < 1) begin
            res.status = ST_UNDERFLOW;
          end else if ((stack_mem[sp - 1] != 8'd0) == (instr.command == CMD_JNZ)) begin
            ip = {1'b0, instr.operand};
          end else begin
            adv = 1'b1;
          end
        end
        CMD_HALT: begin
          halted = 1'b1;
          adv = 1'b1;
        end
        CMD_WRITE: begin
          if (sp < 1) begin
            res.status = ST_UNDERFLOW;
          end else begin
            res.write_valid = 1'b1;
            res.write_byte = stack_mem[sp - 1];
            adv = 1'b1;
          end
        end
        default: res.status = ST_BAD_OPERAND;
      endcase
      if (adv) ip = ip + 9'd1;
    end
    res.next_ip = ip;
    res.halted_flag = halted;
    res.stack_depth = sp[7:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [8:0] exp_v,
                             input logic [8:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sp = 0;
      ip = '0;
      halted = 1'b0;
      plen = PLEN_RESET;
      errors = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: status %0d next_ip %0d",
                 out_data.status, out_data.next_ip);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", {6'd0, want.status}, {6'd0, out_data.status});
          check_field("next_ip", want.next_ip, out_data.next_ip);
          check_field("halted_flag", {8'd0, want.halted_flag},
                      {8'd0, out_data.halted_flag});
          check_field("write_valid", {8'd0, want.write_valid},
                      {8'd0, out_data.write_valid});
          check_field("write_byte", {1'b0, want.write_byte}, {1'b0, out_data.write_byte});
          check_field("stack_depth", {1'b0, want.stack_depth},
                      {1'b0, out_data.stack_depth});
        end
      end
      if (cfg_valid && cfg_ready) plen = cfg_data.program_length;
      if (in_valid && in_ready) expected_results.push_back(execute_instr(in_data));
    end
    pending <= expected_results.size();
  end

endmodule

FILE: tb/sv/byte_stack_machine_execute_core_test.sv
// ----------------------------------------------------------------------------
// byte_stack_machine_execute_core_test
// Drives instructions into the stack machine execute core: a directed run
// over the empty, single entry and full stack corners and every opcode,
// then random phases of push heavy, pop heavy and mixed programs under
// several program lengths, a long receiver hold-off, and a final halt.
// Results are checked by bsm_result_checker.
// ----------------------------------------------------------------------------
module byte_stack_machine_execute_core_test;
  import bsm_pkg::*;

  localparam int STACK_DEPTH    = 255;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  logic       clk;
  logic       rst_n;
  bit         no_idle;
  bit         hold_req;
  int         pending;
  int         errors;
  int         idle_cycles;
  logic [8:0] plen_now;

  bsm_chan_if #(.payload_t(in_item_t))  in_if ();
  bsm_chan_if #(.payload_t(out_item_t)) out_if ();
  bsm_chan_if #(.payload_t(cfg_item_t)) cfg_if ();

  byte_stack_machine_execute_core #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  bsm_result_checker #(.STACK_DEPTH(STACK_DEPTH)) result_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_data   (in_if.data),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_if.data),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready),
    .cfg_data  (cfg_if.data),
    .pending   (pending),
    .errors    (errors)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_if.ready <= no_idle || ($urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_instr(input logic [3:0] command, input logic [7:0] operand);
    in_item_t req;
    req.command = command;
    req.operand = operand;
    while (!no_idle && $urandom_range(0, 99) < 25) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= req;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_plen(input logic [8:0] value);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data.program_length <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    plen_now = value;
  endtask

  // grow: percent of well-formed requests that push
  function automatic in_item_t pick_instr(input int grow, input bit allow_jump,
                                          input logic [8:0] plen);
    in_item_t req;
    int       roll;
    req.operand = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      // noise: any opcode, undefined ones too, but never halt
      req.command = 4'($urandom_range(0, 15));
      if (req.command == CMD_HALT) req.command = CMD_WRITE;
      if (!allow_jump && (req.command == CMD_JUMP || req.command == CMD_JNZ ||
                          req.command == CMD_JZ)) req.command = CMD_POP;
      return req;
    end
    roll = $urandom_range(0, 99);
    if (roll < grow) begin
      req.command = CMD_PUSH;
      case ($urandom_range(0, 7))
        0: req.operand = 8'd0;
        1: req.operand = 8'd255;
        default: ;
      endcase
    end else if (roll < grow + 8) begin
      req.command = CMD_DUP;
      if ($urandom_range(0, 3) != 0) req.operand = 8'($urandom_range(0, 7));
    end else if (roll < grow + 14) begin
      req.command = CMD_WRITE;
    end else if (allow_jump && roll < grow + 26) begin
      case ($urandom_range(0, 2))
        0: req.command = CMD_JUMP;
        1: req.command = CMD_JNZ;
        default: req.command = CMD_JZ;
      endcase
      if (plen != 0 && $urandom_range(0, 7) != 0)
        req.operand = 8'($urandom_range(0, int'(plen) - 1));
    end else begin
      case ($urandom_range(0, 4))
        0: req.command = CMD_ADD;
        1: req.command = CMD_SUB;
        2: req.command = CMD_GT;
        3: req.command = CMD_LT;
        default: req.command = CMD_POP;
      endcase
    end
    return req;
  endfunction

  task automatic run_phase(input int count, input int grow, input bit allow_jump);
    in_item_t req;
    repeat (count) begin
      req = pick_instr(grow, allow_jump, plen_now);
      send_instr(req.command, req.operand);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    plen_now = PLEN_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty stack
    send_instr(CMD_WRITE, 8'd0);
    send_instr(CMD_POP, 8'd0);
    send_instr(CMD_ADD, 8'd0);
    send_instr(CMD_JNZ, 8'd5);
    send_instr(CMD_JZ, 8'd255);
    send_instr(CMD_DUP, 8'd0);
    send_instr(4'd15, 8'd255);
    send_instr(4'd12, 8'd0);
    send_instr(CMD_JUMP, 8'd255);
    // single entry, wrapping arithmetic, equal compare
    send_instr(CMD_PUSH, 8'd255);
    send_instr(CMD_ADD, 8'd0);
    send_instr(CMD_PUSH, 8'd0);
    send_instr(CMD_GT, 8'd0);
    send_instr(CMD_PUSH, 8'd255);
    send_instr(CMD_ADD, 8'd0);
    send_instr(CMD_JZ, 8'd3);
    send_instr(CMD_PUSH, 8'd1);
    send_instr(CMD_SUB, 8'd0);
    send_instr(CMD_DUP, 8'd0);
    send_instr(CMD_LT, 8'd0);
    send_instr(CMD_DUP, 8'd1);
    send_instr(CMD_PUSH, 8'd7);
    send_instr(CMD_DUP, 8'd1);
    send_instr(CMD_WRITE, 8'd0);
    send_instr(CMD_JNZ, 8'd200);
    // no valid jump target at all
    set_plen(9'd0);
    send_instr(CMD_JUMP, 8'd0);
    send_instr(CMD_JZ, 8'd0);

    // fill the stack to the top, then empty it; no jumps so the
    // instruction pointer runs on past 511 in the phase after
    set_plen(PLEN_RESET);
    no_idle = 1'b1;
    repeat (270) send_instr(CMD_PUSH, 8'($urandom_range(0, 255)));
    send_instr(CMD_DUP, 8'd0);
    send_instr(CMD_DUP, 8'd255);
    send_instr(CMD_DUP, 8'd254);
    send_instr(CMD_WRITE, 8'd0);
    no_idle = 1'b0;
    run_phase(280, 0, 1'b0);
    set_plen(9'd255);
    run_phase(600, 45, 1'b0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_plen(9'd1);
        1: set_plen(PLEN_RESET);
        3: set_plen(9'd255);
        4: set_plen(9'd0);
        6: set_plen(PLEN_RESET);
        default: set_plen(9'($urandom_range(2, 255)));
      endcase
      if (p == 3) hold_req = 1'b1;
      case (p % 3)
        0: run_phase(100, 40, 1'b1);
        1: run_phase(100, 60, 1'b1);
        default: run_phase(100, 25, 1'b1);
      endcase
    end

    // halt, after which nothing moves
    send_instr(CMD_HALT, 8'($urandom_range(0, 255)));
    repeat (12) send_instr(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    drain_results();
    repeat (5) @(posedge clk);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
